>>> rtl/tlbf_pkg.sv
`default_nettype none

package tlbf_pkg;

  localparam int unsigned ProcW   = 16;
  localparam int unsigned PageW   = 20;
  localparam int unsigned FrameW  = 16;
  localparam int unsigned SizeW   = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = SizeW;

  localparam logic ActLookup = 1'b0;
  localparam logic ActFill   = 1'b1;

  localparam logic ModeFifo = 1'b0;
  localparam logic ModeLru  = 1'b1;

  localparam logic [CfgIdxW-1:0] RegMode = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSize = 1'b1;

  localparam logic [SizeW-1:0] SizeReset = 6'd32;

  typedef struct packed {
    logic [ProcW-1:0]  proc_id;
    logic [PageW-1:0]  page_num;
    logic [FrameW-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/tlbf_if.sv
`default_nettype none

interface tlbf_in_if;
  import tlbf_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ProcW-1:0]  proc_id;
  logic [PageW-1:0]  page_num;
  logic [FrameW-1:0] fill_frame;

  modport source (output valid, action, proc_id, page_num, fill_frame, input ready);
  modport sink   (input valid, action, proc_id, page_num, fill_frame, output ready);
endinterface

interface tlbf_out_if;
  import tlbf_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [FrameW-1:0] frame_out;
  logic              evicted;

  modport source (output valid, hit, frame_out, evicted, input ready);
  modport sink   (input valid, hit, frame_out, evicted, output ready);
endinterface

`default_nettype wire

>>> rtl/tlb_fifo_lru_lookup.sv
// Channel   Dir  Payload                                   Transfer
// in_if     in   action, proc_id, page_num, fill_frame     valid && ready
// out_if    out  hit, frame_out, evicted                   valid && ready
// cfg       in   cfg_idx_i, cfg_data_i                     cfg_we_i
//
// Each item passes through the transfer, a state that registers the key
// compare of every cell, one that registers the oldest and youngest match,
// and one that updates the cell row and loads the output register.
// The update waits while the output register still holds an untaken result.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module tlb_fifo_lru_lookup #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [tlbf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [tlbf_pkg::CfgDataW-1:0]     cfg_data_i,
  tlbf_in_if.sink                          in_if,
  tlbf_out_if.source                       out_if
);
  import tlbf_pkg::*;

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LimW = (CntW > SizeW) ? CntW : SizeW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCmp  = 2'd1;
  localparam logic [1:0] StSel  = 2'd2;
  localparam logic [1:0] StUpd  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              mode_q;
  logic [SizeW-1:0]  size_q;
  logic [CntW-1:0]   count_q, count_d;

  logic              act_q;
  entry_t            item_q;

  logic [MAX_ENTRIES-1:0] match_q;
  logic [MAX_ENTRIES-1:0] oh_lo_q, oh_hi_q;
  logic                   any_q;

  logic              out_valid_q;
  logic              out_hit_q;
  logic [FrameW-1:0] out_frame_q;
  logic              out_ev_q;

  entry_t                 ent [MAX_ENTRIES];
  cell_ctrl_t             ctrl [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] eq;
  entry_t                 ins;

  logic                   in_xfer, upd_go, full;
  logic [MAX_ENTRIES-1:0] valid_vec, m_vld, m_rev, lo_rev, oh_lo_d, oh_hi_d;
  logic [MAX_ENTRIES-1:0] sel, ge_mask, from_mask;
  logic [FrameW-1:0]      sel_frame;
  logic [IdxW-1:0]        ins_pos;
  logic                   ins_en, hit_now;

  assign in_xfer     = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == StIdle);
  assign upd_go      = (state_q == StUpd) && (!out_valid_q || out_if.ready);

  assign out_if.valid     = out_valid_q;
  assign out_if.hit       = out_hit_q;
  assign out_if.frame_out = out_frame_q;
  assign out_if.evicted   = out_ev_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StCmp;
        end
      end
      StCmp: state_d = StSel;
      StSel: state_d = StUpd;
      StUpd: begin
        if (upd_go) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= ModeFifo;
      size_q      <= SizeReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMode: mode_q <= cfg_data_i[0];
          RegSize: size_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q          <= in_if.action;
      item_q.proc_id <= in_if.proc_id;
      item_q.page_num <= in_if.page_num;
      item_q.frame   <= in_if.fill_frame;
    end
    if (state_q == StCmp) begin
      match_q <= m_vld;
    end
    if (state_q == StSel) begin
      oh_lo_q <= oh_lo_d;
      oh_hi_q <= oh_hi_d;
      any_q   <= |match_q;
    end
    if (upd_go) begin
      out_hit_q   <= hit_now;
      out_frame_q <= hit_now ? sel_frame : '0;
      out_ev_q    <= (act_q == ActFill) && full;
    end
  end

  // Oldest match by isolating the lowest set bit, youngest by doing the same
  // on the reversed vector.
  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      valid_vec[k] = (CntW'(k) < count_q);
      m_rev[k]     = match_q[MAX_ENTRIES-1-k];
    end
    m_vld   = eq & valid_vec;
    oh_lo_d = match_q & (~match_q + MAX_ENTRIES'(1));
    lo_rev  = m_rev & (~m_rev + MAX_ENTRIES'(1));
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      oh_hi_d[k] = lo_rev[MAX_ENTRIES-1-k];
    end
  end

  always_comb begin
    sel       = (mode_q == ModeLru) ? oh_lo_q : oh_hi_q;
    sel_frame = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (sel[k]) begin
        sel_frame = sel_frame | ent[k].frame;
      end
    end
    ge_mask = ~(oh_lo_q - MAX_ENTRIES'(1));
    full    = (LimW'(count_q) >= LimW'(size_q)) || (count_q == CntW'(MAX_ENTRIES));
    hit_now = (act_q == ActLookup) && any_q;

    ins       = item_q;
    from_mask = '0;
    ins_pos   = IdxW'(count_q - CntW'(1));
    ins_en    = 1'b0;
    count_d   = count_q;
    if (act_q == ActLookup) begin
      if ((mode_q == ModeLru) && any_q) begin
        ins.frame = sel_frame;
        from_mask = ge_mask;
        ins_en    = upd_go;
      end
    end else if (full) begin
      from_mask = '1;
      ins_en    = upd_go && (count_q != '0);
    end else begin
      ins_pos = IdxW'(count_q);
      ins_en  = upd_go;
      count_d = upd_go ? count_q + CntW'(1) : count_q;
    end

    for (int k = 0; k < MAX_ENTRIES; k++) begin
      ctrl[k].load  = ins_en && (IdxW'(k) == ins_pos);
      ctrl[k].shift = ins_en && from_mask[k] && (IdxW'(k) < ins_pos);
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    entry_t nb;
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign nb = ins;
    end else begin : g_mid
      assign nb = ent[g+1];
    end

    tlbf_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .ins_i   (ins),
      .nb_i    (nb),
      .entry_o (ent[g]),
      .eq_o    (eq[g])
    );
  end

endmodule

`default_nettype wire

>>> rtl/tlbf_cell.sv
`default_nettype none

module tlbf_cell (
  input  wire                 clk_i,
  input  tlbf_pkg::cell_ctrl_t ctrl_i,
  input  tlbf_pkg::entry_t     ins_i,
  input  tlbf_pkg::entry_t     nb_i,
  output tlbf_pkg::entry_t     entry_o,
  output logic                 eq_o
);
  import tlbf_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = ins_i;
    end else if (ctrl_i.shift) begin
      entry_d = nb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign eq_o    = (entry_q.proc_id == ins_i.proc_id) && (entry_q.page_num == ins_i.page_num);
  assign entry_o = entry_q;

endmodule

`default_nettype wire
